### rtl/quic_coalesced_packet_splitter_top_macros.svh
// Assertion macros shared by the QUIC packet splitter RTL.
`ifndef QUIC_COALESCED_PACKET_SPLITTER_TOP_MACROS_SVH
`define QUIC_COALESCED_PACKET_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QCPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qcps_pkg.sv
// Types and constants shared by the QUIC coalesced packet splitter.
`default_nettype none

package qcps_pkg;

  // Largest datagram handled; later bytes are ignored.
  localparam int unsigned MaxDgBytes = 65536;
  localparam int unsigned OffW       = 16;
  localparam int unsigned LenW       = 17;

  localparam logic [7:0]      LongBit     = 8'h80;
  localparam logic [LenW-1:0] PrefixBytes = LenW'(5);
  localparam logic [31:0]     QuicV2      = 32'h6b3343cf;

  // Parser phases within one packet.
  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_SHORT   = 4'd1,
    PH_VERSION = 4'd2,
    PH_DCIDLEN = 4'd3,
    PH_DCID    = 4'd4,
    PH_SCIDLEN = 4'd5,
    PH_SCID    = 4'd6,
    PH_TOKLEN  = 4'd7,
    PH_TOKEN   = 4'd8,
    PH_LENGTH  = 4'd9,
    PH_PAYLOAD = 4'd10
  } phase_e;

  // One datagram byte request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One boundary report.
  typedef struct packed {
    logic            has_packet;
    logic [OffW-1:0] packet_offset;
    logic [LenW-1:0] packet_length;
    logic            datagram_end;
    logic            malformed;
  } res_t;

endpackage

`default_nettype wire

### rtl/quic_coalesced_packet_splitter_top.sv
// Top level of the QUIC coalesced packet splitter.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_stall_i| has_packet_o, packet_offset_o,
//           |           |                        | packet_length_o, datagram_end_o, malformed_o
//
// One byte request is taken every cycle unless a stalled output holds it;
// the per-byte parser step is the single loop. Reports pass the input and result registers.
// Bytes that cause no report do not wait for the output side.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to
// the start of a datagram; no clearing pass is needed.
// A stalled output only holds the input when the waiting byte has its own report.
`default_nettype none

module quic_coalesced_packet_splitter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               has_packet_o,
  output logic [qcps_pkg::OffW-1:0]          packet_offset_o,
  output logic [qcps_pkg::LenW-1:0]          packet_length_o,
  output logic                               datagram_end_o,
  output logic                               malformed_o
);
  import qcps_pkg::*;

  logic  item_vld;
  item_t item;
  logic  pop;
  logic  out_free;
  logic  res_vld;
  res_t  res;

  // Input register.
  qcps_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_vld_o  (item_vld),
    .item_o      (item),
    .pop_i       (pop)
  );

  // Boundary parser.
  qcps_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .pop_o      (pop),
    .out_free_i (out_free),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // Result register.
  qcps_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_vld_i       (res_vld),
    .res_i           (res),
    .out_free_o      (out_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .has_packet_o    (has_packet_o),
    .packet_offset_o (packet_offset_o),
    .packet_length_o (packet_length_o),
    .datagram_end_o  (datagram_end_o),
    .malformed_o     (malformed_o)
  );

endmodule

`default_nettype wire

### rtl/qcps_in_stage.sv
// Input register holding one datagram byte request until the parser takes it.
`default_nettype none

module qcps_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           last_byte_i,
  output logic                item_vld_o,
  output qcps_pkg::item_t     item_o,
  input  wire logic           pop_i
);
  import qcps_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held request is not being taken this cycle.
  assign in_stall_o = vld_q & ~pop_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register, loaded on every accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{data_byte: data_byte_i, last_byte: last_byte_i};
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

`default_nettype wire

### rtl/qcps_parser.sv
// Header walker: tracks packet boundaries one byte per unstalled cycle, builds reports.
`default_nettype none
`include "quic_coalesced_packet_splitter_top_macros.svh"

module qcps_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_vld_i,
  input  wire qcps_pkg::item_t item_i,
  output logic                pop_o,
  input  wire logic           out_free_i,
  output logic                res_vld_o,
  output qcps_pkg::res_t      res_o
);
  import qcps_pkg::*;

  typedef struct packed {
    logic            done;
    logic [2:0]      left;
    logic [LenW-1:0] value;
  } varint_t;

  localparam logic [OffW:0] LastOff = (OffW + 1)'(MaxDgBytes - 1);

  // One varint byte: first byte sets the size, later bytes shift in and saturate.
  function automatic varint_t varint_step(input logic [7:0] b, input logic [2:0] left,
                                          input logic [LenW-1:0] value);
    varint_t         r;
    logic [LenW+7:0] shifted;
    shifted = {value, b};
    if (left == 3'd0) begin
      r.left  = 3'((4'd1 << b[7:6]) - 4'd1);
      r.value = LenW'(b[5:0]);
      r.done  = (b[7:6] == 2'd0);
    end else begin
      r.value = (shifted > (LenW + 8)'(MaxDgBytes)) ? LenW'(MaxDgBytes)
                                                     : shifted[LenW-1:0];
      r.left  = left - 3'd1;
      r.done  = (r.left == 3'd0);
    end
    return r;
  endfunction

  phase_e          phase_q, phase_d;
  logic [OffW-1:0] byte_off_q, byte_off_d;
  logic [OffW-1:0] pkt_start_q, pkt_start_d;
  logic [LenW-1:0] skip_q, skip_d;
  logic [LenW-1:0] vi_value_q, vi_value_d;
  logic [2:0]      vi_left_q, vi_left_d;
  logic [7:0]      first_q, first_d;
  logic [31:0]     version_q, version_d;
  logic            stopped_q, stopped_d;

  logic            has;
  logic            emit;
  logic [LenW-1:0] skip_dec;
  logic [LenW-1:0] len;
  phase_e          after_scid;
  varint_t         vi;
  logic [7:0]      b;
  res_t            res;

  assign b        = item_i.data_byte;
  assign skip_dec = skip_q - LenW'(1);
  assign vi       = varint_step(b, vi_left_q, vi_value_q);

  // Token field only for Initial packets; the Initial type code depends on the version.
  assign after_scid = (first_q[5:4] == ((version_q == QuicV2) ? 2'd1 : 2'd0))
                      ? PH_TOKLEN : PH_LENGTH;

  // Next state and report for the byte at the head of the input register.
  always_comb begin
    phase_d     = phase_q;
    byte_off_d  = byte_off_q;
    pkt_start_d = pkt_start_q;
    skip_d      = skip_q;
    vi_value_d  = vi_value_q;
    vi_left_d   = vi_left_q;
    first_d     = first_q;
    version_d   = version_q;
    stopped_d   = stopped_q;
    has         = 1'b0;

    if (!stopped_q) begin
      unique case (phase_q)
        PH_FIRST: begin
          pkt_start_d = byte_off_q;
          first_d     = b;
          if ((b & LongBit) == 8'd0) begin
            phase_d = PH_SHORT;
          end else begin
            skip_d    = PrefixBytes - LenW'(1);
            version_d = '0;
            phase_d   = PH_VERSION;
          end
        end
        PH_VERSION: begin
          version_d = {version_q[23:0], b};
          skip_d    = skip_dec;
          if (skip_dec == '0) phase_d = PH_DCIDLEN;
        end
        PH_DCIDLEN: begin
          skip_d  = LenW'(b);
          phase_d = (b == 8'd0) ? PH_SCIDLEN : PH_DCID;
        end
        PH_DCID: begin
          skip_d = skip_dec;
          if (skip_dec == '0) phase_d = PH_SCIDLEN;
        end
        PH_SCIDLEN: begin
          skip_d = LenW'(b);
          if (b == 8'd0) begin
            phase_d   = after_scid;
            vi_left_d = 3'd0;
          end else begin
            phase_d = PH_SCID;
          end
        end
        PH_SCID: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d   = after_scid;
            vi_left_d = 3'd0;
          end
        end
        PH_TOKLEN: begin
          vi_left_d  = vi.left;
          vi_value_d = vi.value;
          if (vi.done) begin
            skip_d  = vi.value;
            phase_d = (vi.value == '0) ? PH_LENGTH : PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d   = PH_LENGTH;
            vi_left_d = 3'd0;
          end
        end
        PH_LENGTH: begin
          vi_left_d  = vi.left;
          vi_value_d = vi.value;
          if (vi.done) begin
            skip_d = vi.value;
            if (vi.value == '0) has = 1'b1;
            else phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          skip_d = skip_dec;
          if (skip_dec == '0) has = 1'b1;
        end
        default: begin
          // Short header: the packet runs to the end of the datagram.
        end
      endcase
      if (item_i.last_byte && (phase_d == PH_SHORT)) has = 1'b1;
    end

    len = has ? (LenW'(byte_off_q) - LenW'(pkt_start_d) + LenW'(1)) : '0;
    if (has) phase_d = PH_FIRST;

    res.has_packet    = has;
    res.packet_offset = pkt_start_d;
    res.packet_length = len;
    res.datagram_end  = item_i.last_byte;
    res.malformed     = item_i.last_byte & ~has;
    emit              = has | item_i.last_byte;

    if (item_i.last_byte) begin
      // Datagram done: everything returns to its reset value.
      phase_d     = PH_FIRST;
      byte_off_d  = '0;
      pkt_start_d = '0;
      skip_d      = '0;
      vi_value_d  = '0;
      vi_left_d   = 3'd0;
      first_d     = '0;
      version_d   = '0;
      stopped_d   = 1'b0;
    end else if ({1'b0, byte_off_q} >= LastOff) begin
      stopped_d = 1'b1;
    end else begin
      byte_off_d = byte_off_q + OffW'(1);
    end
  end

  // Take the byte unless it has a report and the result register is busy.
  assign pop_o     = item_vld_i & (~emit | out_free_i);
  assign res_vld_o = pop_o & emit;
  assign res_o     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      byte_off_q  <= '0;
      pkt_start_q <= '0;
      skip_q      <= '0;
      vi_value_q  <= '0;
      vi_left_q   <= 3'd0;
      first_q     <= '0;
      version_q   <= '0;
      stopped_q   <= 1'b0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      byte_off_q  <= byte_off_d;
      pkt_start_q <= pkt_start_d;
      skip_q      <= skip_d;
      vi_value_q  <= vi_value_d;
      vi_left_q   <= vi_left_d;
      first_q     <= first_d;
      version_q   <= version_d;
      stopped_q   <= stopped_d;
    end
  end

  // A reported packet always covers at least its first byte.
  `QCPS_ASSERT_SAME(a_len_nonzero, res_vld_o && res_o.has_packet,
                    res_o.packet_length != '0, "packet reported with zero length")
  // Every report carries either a packet or a malformed flag, never both.
  `QCPS_ASSERT_SAME(a_has_xor_bad, res_vld_o, res_o.has_packet != res_o.malformed,
                    "report with inconsistent packet and malformed flags")
  // Splitting stops only once the offset has reached the datagram bound.
  `QCPS_ASSERT_SAME(a_stop_at_bound, stopped_q, {1'b0, byte_off_q} == LastOff,
                    "splitter stopped before the datagram bound")
  // The byte after a datagram's last byte starts from a clean state.
  `QCPS_ASSERT_NEXT(a_clean_restart, pop_o && item_i.last_byte,
                    phase_q == PH_FIRST && byte_off_q == '0 && !stopped_q,
                    "state not cleared after datagram end")

endmodule

`default_nettype wire

### rtl/qcps_out_stage.sv
// Result register presenting one boundary report to the downstream side.
`default_nettype none

module qcps_out_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          res_vld_i,
  input  wire qcps_pkg::res_t                res_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               has_packet_o,
  output logic [qcps_pkg::OffW-1:0]          packet_offset_o,
  output logic [qcps_pkg::LenW-1:0]          packet_length_o,
  output logic                               datagram_end_o,
  output logic                               malformed_o
);
  import qcps_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  // The register can take a new report when empty or being drained now.
  assign out_free_o = ~vld_q | ~out_stall_i;
  assign vld_d      = res_vld_i | (vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = vld_q;
  assign has_packet_o    = res_q.has_packet;
  assign packet_offset_o = res_q.packet_offset;
  assign packet_length_o = res_q.packet_length;
  assign datagram_end_o  = res_q.datagram_end;
  assign malformed_o     = res_q.malformed;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the QUIC coalesced packet splitter, directed and random datagrams.

module tb;
  import qcps_pkg::*;

  localparam int MAX_GAP      = 8;
  localparam int HOLD_LEN     = 300;
  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_REPORTS  = 20;

  // Receiver stall behaviour, redrawn at random whenever the current mode runs out.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_e;

  // One byte waiting to be offered; hold_first makes the sender wait for all reports.
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold_first;
  } byte_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      data_byte = 8'h00;
  logic            last_byte = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            has_packet;
  logic [OffW-1:0] packet_offset;
  logic [LenW-1:0] packet_length;
  logic            datagram_end;
  logic            malformed;

  quic_coalesced_packet_splitter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .has_packet_o   (has_packet),
    .packet_offset_o(packet_offset),
    .packet_length_o(packet_length),
    .datagram_end_o (datagram_end),
    .malformed_o    (malformed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  byte_req_t  byte_q[$];
  logic [7:0] dgram_q[$];
  res_t       boundary_q[$];

  int    mismatches = 0;
  int    outstanding = 0;
  int    sent_cnt = 0;
  int    dgram_cnt = 0;
  int    packet_cnt = 0;
  int    truncated_cnt = 0;
  int    hold_count = 0;
  longint cycles = 0;
  longint cycle_limit = 64'd100000000;

  // Boundary walker state, kept apart from the block under test.
  phase_e          sp_phase;
  logic [OffW-1:0] sp_off;
  logic [OffW-1:0] sp_start;
  logic [LenW-1:0] sp_skip;
  logic [LenW-1:0] sp_vval;
  logic [2:0]      sp_vleft;
  logic [7:0]      sp_first;
  logic [31:0]     sp_ver;
  bit              sp_stopped;

  function void clear_splitter();
    sp_phase   = PH_FIRST;
    sp_off     = '0;
    sp_start   = '0;
    sp_skip    = '0;
    sp_vval    = '0;
    sp_vleft   = '0;
    sp_first   = '0;
    sp_ver     = '0;
    sp_stopped = 1'b0;
  endfunction

  // Takes one varint byte and returns 1 once the value is complete; values saturate.
  function bit feed_varint(logic [7:0] b);
    int unsigned acc;
    if (sp_vleft == 3'd0) begin
      sp_vleft = 3'((1 << b[7:6]) - 1);
      sp_vval  = LenW'(b[5:0]);
      return sp_vleft == 3'd0;
    end
    acc = 32'(sp_vval) * 256 + 32'(b);
    if (acc > MaxDgBytes) acc = MaxDgBytes;
    sp_vval  = LenW'(acc);
    sp_vleft = sp_vleft - 3'd1;
    return sp_vleft == 3'd0;
  endfunction

  // Initial packets carry a token; the type bits that mean Initial depend on the version.
  function phase_e after_cids();
    logic [1:0] init_bits;
    init_bits = (sp_ver == QuicV2) ? 2'd1 : 2'd0;
    return (sp_first[5:4] == init_bits) ? PH_TOKLEN : PH_LENGTH;
  endfunction

  // Advances the boundary walk by one byte and queues the report it causes, if any.
  function void predict_boundary(logic [7:0] b, logic lst);
    bit              done;
    logic [LenW-1:0] len;
    res_t            rep;
    done = 1'b0;
    if (!sp_stopped) begin
      case (sp_phase)
        PH_FIRST: begin
          sp_start = sp_off;
          sp_first = b;
          if ((b & LongBit) == 8'h00) begin
            sp_phase = PH_SHORT;
          end else begin
            sp_skip  = PrefixBytes - 1'b1;
            sp_ver   = '0;
            sp_phase = PH_VERSION;
          end
        end
        PH_VERSION: begin
          sp_ver  = {sp_ver[23:0], b};
          sp_skip = sp_skip - 1'b1;
          if (sp_skip == '0) sp_phase = PH_DCIDLEN;
        end
        PH_DCIDLEN: begin
          sp_skip  = LenW'(b);
          sp_phase = (b == 8'h00) ? PH_SCIDLEN : PH_DCID;
        end
        PH_DCID: begin
          sp_skip = sp_skip - 1'b1;
          if (sp_skip == '0) sp_phase = PH_SCIDLEN;
        end
        PH_SCIDLEN: begin
          sp_skip = LenW'(b);
          if (b == 8'h00) begin
            sp_phase = after_cids();
            sp_vleft = '0;
          end else begin
            sp_phase = PH_SCID;
          end
        end
        PH_SCID: begin
          sp_skip = sp_skip - 1'b1;
          if (sp_skip == '0) begin
            sp_phase = after_cids();
            sp_vleft = '0;
          end
        end
        PH_TOKLEN: begin
          if (feed_varint(b)) begin
            sp_skip  = sp_vval;
            sp_phase = (sp_skip == '0) ? PH_LENGTH : PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          sp_skip = sp_skip - 1'b1;
          if (sp_skip == '0) begin
            sp_phase = PH_LENGTH;
            sp_vleft = '0;
          end
        end
        PH_LENGTH: begin
          if (feed_varint(b)) begin
            sp_skip = sp_vval;
            if (sp_skip == '0) done = 1'b1;
            else sp_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sp_skip = sp_skip - 1'b1;
          if (sp_skip == '0) done = 1'b1;
        end
        default: ;
      endcase
      // A short-header packet runs to the end of the datagram.
      if (lst && sp_phase == PH_SHORT) done = 1'b1;
    end

    len = done ? LenW'(sp_off) - LenW'(sp_start) + 1'b1 : '0;
    if (done) sp_phase = PH_FIRST;
    rep.has_packet    = done;
    rep.packet_offset = sp_start;
    rep.packet_length = len;
    rep.datagram_end  = lst;
    rep.malformed     = lst && !done;

    if (lst) begin
      boundary_q.push_back(rep);
      clear_splitter();
    end else begin
      // Past the largest datagram the walk freezes until the last byte.
      if (sp_off == OffW'(MaxDgBytes - 1)) sp_stopped = 1'b1;
      else sp_off = sp_off + 1'b1;
      if (done) boundary_q.push_back(rep);
    end
  endfunction

  // Datagram building.
  function void put_byte(logic [7:0] b);
    dgram_q.push_back(b);
  endfunction

  function void add_random_bytes(int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_byte(8'($urandom));
  endfunction

  function void add_varint(logic [63:0] v, int nb);
    logic [63:0] enc;
    logic [1:0]  code;
    code = (nb == 1) ? 2'd0 : (nb == 2) ? 2'd1 : (nb == 4) ? 2'd2 : 2'd3;
    enc  = v & ((64'd1 << (8 * nb - 2)) - 64'd1);
    enc  = enc | (64'(code) << (8 * nb - 2));
    for (int i = nb - 1; i >= 0; i--) put_byte(enc[8 * i +: 8]);
  endfunction

  // Mostly the shortest encoding, sometimes a longer one.
  function int pick_varint_bytes(int unsigned v);
    int nb;
    nb = (v < 64) ? 1 : (v < 16384) ? 2 : 4;
    if ($urandom_range(0, 4) == 0) nb = (nb == 1) ? 2 : (nb == 2) ? 4 : 8;
    if ($urandom_range(0, 19) == 0) nb = 8;
    return nb;
  endfunction

  function int unsigned pick_cid_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(5, 20);
    if (r < 98) return $urandom_range(21, 254);
    return 255;
  endfunction

  function void add_long_packet();
    logic [31:0] ver;
    logic [1:0]  tbits;
    logic [1:0]  init_bits;
    int unsigned n;
    int unsigned r;
    r = $urandom_range(0, 3);
    ver = (r == 0) ? QuicV2 : (r == 1) ? 32'h1 : (r == 2) ? 32'($urandom) : 32'h0;
    init_bits = (ver == QuicV2) ? 2'd1 : 2'd0;
    tbits = ($urandom_range(0, 1) == 0) ? init_bits : 2'($urandom);
    put_byte({1'b1, 1'($urandom), tbits, 4'($urandom)});
    for (int i = 3; i >= 0; i--) put_byte(ver[8 * i +: 8]);
    n = pick_cid_len();
    put_byte(8'(n));
    add_random_bytes(n);
    n = pick_cid_len();
    put_byte(8'(n));
    add_random_bytes(n);
    if (tbits == init_bits) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 120) : $urandom_range(0, 6);
      add_varint(64'(n), pick_varint_bytes(n));
      add_random_bytes(n);
    end
    n = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 12);
    add_varint(64'(n), pick_varint_bytes(n));
    add_random_bytes(n);
  endfunction

  function void add_short_packet(int unsigned n);
    put_byte({1'b0, 7'($urandom)});
    add_random_bytes(n - 1);
  endfunction

  // Moves the datagram under construction into the sender's queue.
  function void flush_datagram(bit wait_idle);
    for (int i = 0; i < dgram_q.size(); i++) begin
      byte_q.push_back('{data: dgram_q[i], last: (i == dgram_q.size() - 1),
                         hold_first: (wait_idle && i == 0)});
    end
    dgram_q.delete();
    dgram_cnt++;
  endfunction

  // Sender: bursts of random length, random gaps, and waits for drained reports on request.
  byte_req_t drv_req;
  bit        drv_next;
  bit        idle_wait = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) sent_cnt <= sent_cnt + 1;
      drv_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_q.size() != 0 &&
                   (!byte_q[0].hold_first || (idle_wait && outstanding == 0))) begin
        drv_req   = byte_q.pop_front();
        idle_wait = 1'b0;
        data_byte <= drv_req.data;
        last_byte <= drv_req.last;
        drv_next  = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(100, 400);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = $urandom_range(0, MAX_GAP);
        end
      end else if (byte_q.size() != 0) begin
        // The outstanding count is registered, so the wait flag is set here and checked on a later edge.
        idle_wait = 1'b1;
      end
      in_valid <= drv_next;
    end
  end

  // Receiver: stall modes of its own plus occasional long hold-offs while bytes stream in.
  rx_mode_e rcv_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       next_hold_at = 300;
  int       rcv_tick = 0;
  bit       rcv_stall;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rcv_tick++;
      if (hold_left > 0) begin
        hold_left--;
        rcv_stall = 1'b1;
      end else if (sent_cnt >= next_hold_at) begin
        hold_left    = HOLD_LEN - 1;
        next_hold_at = next_hold_at + ((next_hold_at < 1000) ? 500 : 30000);
        hold_count++;
        rcv_stall    = 1'b1;
      end else begin
        if (mode_left > 0) begin
          mode_left--;
        end else begin
          rcv_mode  = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(30, 200);
        end
        case (rcv_mode)
          RX_FREE:  rcv_stall = 1'b0;
          RX_LIGHT: rcv_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY: rcv_stall = ($urandom_range(0, 3) != 0);
          default:  rcv_stall = ((rcv_tick % 7) < 3);
        endcase
      end
      out_stall <= rcv_stall;
    end
  end

  function void check_field(string name, logic [LenW-1:0] want, logic [LenW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: predicts on every accepted byte, then checks every accepted report in order.
  res_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_boundary(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (boundary_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected report, expected none, got offset %0d length %0d",
                     $time, packet_offset, packet_length);
        end else begin
          exp_res = boundary_q.pop_front();
          if (exp_res.has_packet) packet_cnt++;
          if (exp_res.malformed) truncated_cnt++;
          check_field("has_packet", LenW'(exp_res.has_packet), LenW'(has_packet));
          check_field("packet_offset", LenW'(exp_res.packet_offset), LenW'(packet_offset));
          check_field("packet_length", exp_res.packet_length, packet_length);
          check_field("datagram_end", LenW'(exp_res.datagram_end), LenW'(datagram_end));
          check_field("malformed", LenW'(exp_res.malformed), LenW'(malformed));
        end
      end
      outstanding <= boundary_q.size();
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == cycle_limit) begin
      $display("Timeout after %0d cycles with %0d reports still due", cycles, boundary_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          start_size;
    int unsigned n_pk;
    int unsigned r;
    int unsigned cut;

    clear_splitter();

    // Lone short-header byte, then a lone long-header byte that truncates at once.
    put_byte(8'h00);
    flush_datagram(1'b0);
    put_byte(8'hff);
    flush_datagram(1'b0);

    // Version 1 Handshake with empty IDs and zero Length, then a two-byte short packet.
    put_byte(8'he0);
    put_byte(8'h00); put_byte(8'h00); put_byte(8'h00); put_byte(8'h01);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h7f);
    put_byte(8'hff);
    flush_datagram(1'b0);

    // Version 2 Initial with an empty token, a two-byte Length, ending on the last byte.
    put_byte(8'hd0);
    put_byte(8'h6b); put_byte(8'h33); put_byte(8'h43); put_byte(8'hcf);
    put_byte(8'h01);
    put_byte(8'hff);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h40); put_byte(8'h01);
    put_byte(8'hff);
    flush_datagram(1'b0);

    // Random datagrams: mostly well formed, some truncated, some plain noise.
    start_size = byte_q.size();
    while (byte_q.size() - start_size < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        add_short_packet($urandom_range(1, 6));
      end else begin
        n_pk = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n_pk; k++) begin
          if (k == n_pk - 1 && $urandom_range(0, 2) == 0)
            add_short_packet($urandom_range(1, 30));
          else
            add_long_packet();
        end
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        dgram_q.delete();
        add_random_bytes($urandom_range(1, 24));
      end else if (r < 20 && dgram_q.size() > 1) begin
        cut = $urandom_range(1, dgram_q.size() - 1);
        while (dgram_q.size() > cut) void'(dgram_q.pop_back());
      end
      flush_datagram($urandom_range(0, 9) == 0);
    end

    // Closing datagram, sent only once every earlier report has come back.
    add_short_packet(16);
    flush_datagram(1'b1);

    // Worst case per byte: the longest sender gap plus a report waiting out stalls.
    cycle_limit = 3 * (longint'(byte_q.size()) * (MAX_GAP + 8) + 40 * HOLD_LEN) + 20000;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_valid || boundary_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d datagrams in %0d bytes, %0d long output hold-offs.",
             dgram_cnt, sent_cnt, hold_count);
    $display("Reports checked: %0d packet boundaries, %0d truncated datagram ends.",
             packet_cnt, truncated_cnt);
    if (mismatches == 0 && boundary_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
